// ===== hdl/upd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package upd_pkg;

	// Code units that the path grammar looks at.
	localparam logic [15:0] UNIT_SLASH     = 16'h002F;
	localparam logic [15:0] UNIT_PERCENT   = 16'h0025;
	localparam logic [15:0] UNIT_QUESTION  = 16'h003F;
	localparam logic [15:0] UNIT_HASH      = 16'h0023;
	localparam logic [15:0] UNIT_SPACE     = 16'h0020;
	localparam logic [15:0] UNIT_BACKSLASH = 16'h005C;
	localparam logic [15:0] UNIT_CTRL_MAX  = 16'h001F;
	localparam logic [15:0] UNIT_DEL       = 16'h007F;

	localparam logic [20:0] CP_SLASH     = 21'h00002F;
	localparam logic [20:0] CP_BACKSLASH = 21'h00005C;
	localparam logic [20:0] CP_DOT       = 21'h00002E;
	localparam logic [20:0] CP_CTRL_MAX  = 21'h00001F;
	localparam logic [20:0] CP_DEL       = 21'h00007F;
	localparam logic [20:0] CP_BOM       = 21'h00FEFF;

	// Where we are inside a %XX escape.
	typedef enum logic [1:0] {
		ESC_NONE = 2'd0,
		ESC_HIGH = 2'd1,
		ESC_LOW  = 2'd2
	} upd_esc_t;

	// Which lead byte narrows the range of the first continuation byte.
	typedef enum logic [2:0] {
		LEAD_ANY = 3'd0,
		LEAD_E0  = 3'd1,
		LEAD_ED  = 3'd2,
		LEAD_F0  = 3'd3,
		LEAD_F4  = 3'd4
	} upd_lead_t;

	typedef struct packed {
		logic       path_started;
		logic       after_slash;
		upd_esc_t   escape_phase;
		logic [3:0] escape_high;
		logic [1:0] utf8_pending;
		logic [20:0] utf8_value;
		upd_lead_t  utf8_lead_class;
		logic       segment_fresh;
		logic [1:0] dot_run;
		logic       failed;
	} upd_state_t;

	localparam upd_state_t ST_RESET = '{
		path_started:    1'b0,
		after_slash:     1'b0,
		escape_phase:    ESC_NONE,
		escape_high:     4'd0,
		utf8_pending:    2'd0,
		utf8_value:      21'd0,
		utf8_lead_class: LEAD_ANY,
		segment_fresh:   1'b1,
		dot_run:         2'd0,
		failed:          1'b0
	};

	// Outcome of pushing one byte through the UTF-8 decoder.
	typedef struct packed {
		logic [1:0]  utf8_pending;
		logic [20:0] utf8_value;
		upd_lead_t   utf8_lead_class;
		logic        segment_fresh;
		logic [1:0]  dot_run;
		logic        fail;
		logic        cp_valid;
		logic [20:0] cp;
	} upd_byte_out_t;

	// One result word.
	typedef struct packed {
		logic        char_valid;
		logic [20:0] code_point;
		logic        segment_end;
		logic        path_done;
		logic        accepted;
	} upd_result_t;

endpackage

`default_nettype wire

// ===== hdl/upd_byte.sv =====
`timescale 1ns / 1ps
`default_nettype none

// UTF-8 byte decoder with the per code point checks of a segment.
module upd_byte (
	input  wire upd_pkg::upd_state_t    st,
	input  wire logic [7:0]             byte_in,
	output upd_pkg::upd_byte_out_t      bo
);

	logic        done;
	logic [20:0] done_cp;
	logic [20:0] acc;
	logic [7:0]  lo;
	logic [7:0]  hi;
	logic [1:0]  pend_dec;

	always_comb begin
		bo = '{
			utf8_pending:    st.utf8_pending,
			utf8_value:      st.utf8_value,
			utf8_lead_class: st.utf8_lead_class,
			segment_fresh:   st.segment_fresh,
			dot_run:         st.dot_run,
			fail:            1'b0,
			cp_valid:        1'b0,
			cp:              21'd0
		};
		done     = 1'b0;
		done_cp  = 21'd0;
		acc      = {st.utf8_value[14:0], byte_in[5:0]};
		pend_dec = st.utf8_pending - 2'd1;
		lo       = 8'h80;
		hi       = 8'hBF;

		unique case (st.utf8_lead_class)
			upd_pkg::LEAD_E0: lo = 8'hA0;
			upd_pkg::LEAD_ED: hi = 8'h9F;
			upd_pkg::LEAD_F0: lo = 8'h90;
			upd_pkg::LEAD_F4: hi = 8'h8F;
			default: ;
		endcase

		if (st.utf8_pending == 2'd0) begin
			if (byte_in < 8'h80) begin
				done    = 1'b1;
				done_cp = {13'd0, byte_in};
			end else if (byte_in >= 8'hC2 && byte_in <= 8'hDF) begin
				bo.utf8_value      = {16'd0, byte_in[4:0]};
				bo.utf8_pending    = 2'd1;
				bo.utf8_lead_class = upd_pkg::LEAD_ANY;
			end else if (byte_in >= 8'hE0 && byte_in <= 8'hEF) begin
				bo.utf8_value   = {17'd0, byte_in[3:0]};
				bo.utf8_pending = 2'd2;
				if (byte_in == 8'hE0) begin
					bo.utf8_lead_class = upd_pkg::LEAD_E0;
				end else if (byte_in == 8'hED) begin
					bo.utf8_lead_class = upd_pkg::LEAD_ED;
				end else begin
					bo.utf8_lead_class = upd_pkg::LEAD_ANY;
				end
			end else if (byte_in >= 8'hF0 && byte_in <= 8'hF4) begin
				bo.utf8_value   = {18'd0, byte_in[2:0]};
				bo.utf8_pending = 2'd3;
				if (byte_in == 8'hF0) begin
					bo.utf8_lead_class = upd_pkg::LEAD_F0;
				end else if (byte_in == 8'hF4) begin
					bo.utf8_lead_class = upd_pkg::LEAD_F4;
				end else begin
					bo.utf8_lead_class = upd_pkg::LEAD_ANY;
				end
			end else begin
				bo.fail = 1'b1;
			end
		end else if (byte_in < lo || byte_in > hi) begin
			bo.fail = 1'b1;
		end else begin
			bo.utf8_value      = acc;
			bo.utf8_lead_class = upd_pkg::LEAD_ANY;
			bo.utf8_pending    = pend_dec;
			if (pend_dec == 2'd0) begin
				done    = 1'b1;
				done_cp = acc;
			end
		end

		// A byte order mark that opens a segment is swallowed silently.
		if (done) begin
			bo.segment_fresh = 1'b0;
			if (!(st.segment_fresh && done_cp == upd_pkg::CP_BOM)) begin
				if (done_cp == upd_pkg::CP_SLASH || done_cp == upd_pkg::CP_BACKSLASH ||
				    done_cp <= upd_pkg::CP_CTRL_MAX || done_cp == upd_pkg::CP_DEL) begin
					bo.fail = 1'b1;
				end else begin
					if (done_cp == upd_pkg::CP_DOT) begin
						bo.dot_run = (st.dot_run >= 2'd2) ? 2'd3 : st.dot_run + 2'd1;
					end else begin
						bo.dot_run = 2'd3;
					end
					bo.cp_valid = 1'b1;
					bo.cp       = done_cp;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/upd_step.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Next state and result word for one code unit of the path.
module upd_step (
	input  wire upd_pkg::upd_state_t  st,
	input  wire logic [15:0]          code_unit,
	input  wire logic                 last,
	output upd_pkg::upd_state_t       st_next,
	output upd_pkg::upd_result_t      res
);

	upd_pkg::upd_state_t    m;
	upd_pkg::upd_byte_out_t bo;
	logic [7:0]             byte_sel;
	logic [7:0]             esc_byte;
	logic [3:0]             hexv;
	logic                   hex_ok;
	logic                   feed;
	logic                   close_en;
	logic                   cpv;
	logic [20:0]            cp;
	logic                   segend;

	function automatic logic unreserved(input logic [7:0] b);
		unreserved = (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
		             (b >= 8'h30 && b <= 8'h39) || b == 8'h2D || b == 8'h2E ||
		             b == 8'h5F || b == 8'h7E;
	endfunction

	always_comb begin
		hex_ok = 1'b1;
		hexv   = 4'd0;
		if (code_unit >= 16'h0030 && code_unit <= 16'h0039) begin
			hexv = code_unit[3:0];
		end else if (code_unit >= 16'h0041 && code_unit <= 16'h0046) begin
			hexv = code_unit[3:0] + 4'd9;
		end else begin
			hex_ok = 1'b0;
		end
		esc_byte = {st.escape_high, hexv};
		byte_sel = (st.escape_phase == upd_pkg::ESC_NONE) ? code_unit[7:0] : esc_byte;
	end

	upd_byte u_byte (
		.st      (st),
		.byte_in (byte_sel),
		.bo      (bo)
	);

	always_comb begin
		m        = st;
		feed     = 1'b0;
		close_en = 1'b0;
		cpv      = 1'b0;
		cp       = 21'd0;
		segend   = 1'b0;

		if (!st.failed) begin
			if (!st.path_started) begin
				m.path_started = 1'b1;
				if (code_unit != upd_pkg::UNIT_SLASH) begin
					m.failed = 1'b1;
				end else begin
					m.after_slash = 1'b1;
				end
			end else if (code_unit == upd_pkg::UNIT_SLASH) begin
				if (st.after_slash || last) begin
					m.failed = 1'b1;
				end else begin
					close_en      = 1'b1;
					m.after_slash = 1'b1;
				end
			end else if (code_unit == upd_pkg::UNIT_QUESTION ||
			             code_unit == upd_pkg::UNIT_HASH) begin
				m.failed = 1'b1;
			end else begin
				m.after_slash = 1'b0;
				if (st.escape_phase == upd_pkg::ESC_NONE) begin
					if (code_unit == upd_pkg::UNIT_PERCENT) begin
						m.escape_phase = upd_pkg::ESC_HIGH;
					end else if (code_unit > upd_pkg::UNIT_DEL ||
					             code_unit <= upd_pkg::UNIT_CTRL_MAX ||
					             code_unit == upd_pkg::UNIT_DEL ||
					             code_unit == upd_pkg::UNIT_BACKSLASH ||
					             code_unit == upd_pkg::UNIT_SPACE) begin
						m.failed = 1'b1;
					end else begin
						feed = 1'b1;
					end
				end else if (!hex_ok) begin
					m.failed = 1'b1;
				end else if (st.escape_phase == upd_pkg::ESC_HIGH) begin
					m.escape_high  = hexv;
					m.escape_phase = upd_pkg::ESC_LOW;
				end else begin
					m.escape_phase = upd_pkg::ESC_NONE;
					if (unreserved(esc_byte)) begin
						m.failed = 1'b1;
					end else begin
						feed = 1'b1;
					end
				end

				if (feed) begin
					m.utf8_pending    = bo.utf8_pending;
					m.utf8_value      = bo.utf8_value;
					m.utf8_lead_class = bo.utf8_lead_class;
					m.segment_fresh   = bo.segment_fresh;
					m.dot_run         = bo.dot_run;
					m.failed          = bo.fail;
					cpv               = bo.cp_valid;
					cp                = bo.cp;
				end
				close_en = last && !m.failed;
			end
		end

		// Closing a segment: a dangling escape or sequence, or a dot segment, is rejected.
		if (close_en) begin
			if (m.escape_phase != upd_pkg::ESC_NONE || m.utf8_pending != 2'd0 ||
			    m.dot_run == 2'd1 || m.dot_run == 2'd2) begin
				m.failed = 1'b1;
			end
			segend            = 1'b1;
			m.escape_phase    = upd_pkg::ESC_NONE;
			m.escape_high     = 4'd0;
			m.utf8_pending    = 2'd0;
			m.utf8_value      = 21'd0;
			m.utf8_lead_class = upd_pkg::LEAD_ANY;
			m.segment_fresh   = 1'b1;
			m.dot_run         = 2'd0;
		end

		res.char_valid  = cpv && !m.failed;
		res.code_point  = m.failed ? 21'd0 : cp;
		res.segment_end = segend && !m.failed;
		res.path_done   = last;
		res.accepted    = !m.failed;

		st_next = last ? upd_pkg::ST_RESET : m;
	end

endmodule

`default_nettype wire

// ===== hdl/url_path_percent_decoder.sv =====
// URL path validator and percent decoder. Each input word is one UTF-16 code unit of a
// path, with last set on its final unit; each produces exactly one result word. A result
// reports a completed decoded code point (char_valid, code_point), the close of a non-empty
// segment (segment_end), the end of the path (path_done), and whether the path is still
// acceptable (accepted, the verdict on the path_done word). Once a rule is broken the path
// stays rejected until its last unit, and decoding state returns to reset after every last
// unit. The block takes one word per clock cycle and sustains that rate indefinitely while
// the output side keeps taking words: the only feedback loop is the running path state,
// which the step logic computes combinationally and which is registered once per word. A
// word goes through an input register and then the result register, moving on into the
// result register once that register is empty or its word is being taken. No clearing
// pass is needed after reset.
`timescale 1ns / 1ps
`default_nettype none

module url_path_percent_decoder (
	input  wire logic        clk,
	input  wire logic        arst_n,

	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [15:0] code_unit,
	input  wire logic        last,

	output logic             out_valid,
	input  wire logic        out_ready,
	output logic             char_valid,
	output logic [20:0]      code_point,
	output logic             segment_end,
	output logic             path_done,
	output logic             accepted
);

	// Input register stage.
	logic                 valid_s1;
	logic [15:0]          code_unit_s1;
	logic                 last_s1;

	// Result register stage.
	logic                 valid_s2;
	upd_pkg::upd_result_t result_s2;

	// Running path state.
	upd_pkg::upd_state_t  state_q;
	upd_pkg::upd_state_t  state_next;
	upd_pkg::upd_result_t result_next;

	logic                 load_s2;

	// The result register loads whenever it is empty or its word is being taken, so
	// the input stage drains in the same cycle and can accept another word.
	assign load_s2  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || load_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			code_unit_s1 <= code_unit;
			last_s1      <= last;
		end
	end

	upd_step u_step (
		.st        (state_q),
		.code_unit (code_unit_s1),
		.last      (last_s1),
		.st_next   (state_next),
		.res       (result_next)
	);

	// The path state advances exactly once per word, when that word's result is registered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= upd_pkg::ST_RESET;
		end else if (load_s2) begin
			state_q <= state_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			result_s2 <= result_next;
		end
	end

	assign out_valid   = valid_s2;
	assign char_valid  = result_s2.char_valid;
	assign code_point  = result_s2.code_point;
	assign segment_end = result_s2.segment_end;
	assign path_done   = result_s2.path_done;
	assign accepted    = result_s2.accepted;

endmodule

`default_nettype wire

// ===== hdl/upd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module upd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic [15:0] code_unit,
	input wire logic        last,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic        char_valid,
	input wire logic [20:0] code_point,
	input wire logic        segment_end,
	input wire logic        path_done,
	input wire logic        accepted
);

	// An input word that is not yet taken holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(code_unit) && $stable(last))
		else $error("input word changed while waiting");

	// A stalled result word holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_point) &&
		$stable(char_valid) && $stable(accepted) && $stable(path_done))
		else $error("result word changed while stalled");

	// A rejected path reports nothing else.
	a_reject_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accepted |-> !char_valid && !segment_end && code_point == 21'd0)
		else $error("rejected word carries a character or segment end");

	// Decoded code points are scalar values.
	a_cp_scalar: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> code_point <= 21'h10FFFF &&
		(code_point < 21'h00D800 || code_point > 21'h00DFFF))
		else $error("decoded code point out of range or a surrogate");

	// Characters that split or escape a path never come out.
	a_cp_allowed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && char_valid |-> code_point > 21'h00001F && code_point != 21'h00007F &&
		code_point != 21'h00002F && code_point != 21'h00005C)
		else $error("forbidden code point delivered");

endmodule

bind url_path_percent_decoder upd_checker u_upd_checker (.*);

`default_nettype wire
